// File: rtl/lsu_pkg.sv
// Package for the load/store unit: sizes, width codes, status codes
// and the access descriptor passed from decode to the pipeline.
// No dependencies.
package lsu_pkg;

  localparam int MEM_WORDS = 16384;
  localparam int IDX_W     = $clog2(MEM_WORDS);
  localparam int ADDR_W    = 32;
  localparam int DATA_W    = 32;
  localparam int OFFSET_W  = 12;
  localparam int WC_W      = 3;
  localparam int REG_W     = 5;
  localparam int BYTE_W    = 8;
  localparam int HALF_W    = 16;
  localparam int LANES     = DATA_W / BYTE_W;
  localparam int LANE_W    = $clog2(LANES);
  localparam int WIDX_W    = ADDR_W - LANE_W;

  localparam logic [WIDX_W-1:0] MEM_LIMIT = WIDX_W'(MEM_WORDS);

  localparam logic [WC_W-1:0] WC_BYTE  = 3'd0;
  localparam logic [WC_W-1:0] WC_HALF  = 3'd1;
  localparam logic [WC_W-1:0] WC_WORD  = 3'd2;
  localparam logic [WC_W-1:0] WC_BYTEU = 3'd4;
  localparam logic [WC_W-1:0] WC_HALFU = 3'd5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_BAD_WIDTH  = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SZ_NONE = 2'd0,
    SZ_BYTE = 2'd1,
    SZ_HALF = 2'd2,
    SZ_WORD = 2'd3
  } size_t;

  typedef struct packed {
    status_t           status;
    logic              reg_write;
    logic              mem_en;
    logic              mem_we;
    logic [LANES-1:0]  byte_en;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wdata;
  } access_t;

endpackage

// File: rtl/lsu_ram.sv
// Generic single-port RAM with per-byte write enables and registered read.
// No dependencies.
module lsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [WIDTH/8-1:0]       be,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      for (int i = 0; i < WIDTH / 8; i++) begin
        if (be[i]) begin
          mem[addr][i*8 +: 8] <= wdata[i*8 +: 8];
        end
      end
    end
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/lsu_decode.sv
// Access decode: width check, alignment, range, byte enables, store lanes.
// Depends on lsu_pkg.
module lsu_decode (
  input  logic                   command,
  input  logic [lsu_pkg::ADDR_W-1:0] addr,
  input  logic [lsu_pkg::DATA_W-1:0] store_data,
  input  logic [lsu_pkg::WC_W-1:0]   width_code,
  output lsu_pkg::access_t       acc
);
  import lsu_pkg::*;

  size_t             size;
  logic [LANE_W-1:0] lane;
  logic              misaligned;
  logic              in_range;

  assign lane     = addr[LANE_W-1:0];
  assign in_range = addr[ADDR_W-1:LANE_W] < MEM_LIMIT;

  always_comb begin
    case (width_code)
      WC_BYTE, WC_BYTEU: size = SZ_BYTE;
      WC_HALF, WC_HALFU: size = SZ_HALF;
      WC_WORD:           size = SZ_WORD;
      default:           size = SZ_NONE;
    endcase
  end

  always_comb begin
    case (size)
      SZ_HALF: misaligned = lane[0];
      SZ_WORD: misaligned = lane != '0;
      default: misaligned = 1'b0;
    endcase
  end

  always_comb begin
    acc.idx       = addr[IDX_W+LANE_W-1:LANE_W];
    acc.reg_write = 1'b0;
    acc.mem_en    = 1'b0;
    acc.mem_we    = command == CMD_STORE;
    case (size)
      SZ_BYTE: begin
        acc.byte_en = LANES'(1) << lane;
        acc.wdata   = {LANES{store_data[BYTE_W-1:0]}};
      end
      SZ_HALF: begin
        acc.byte_en = lane[1] ? 4'b1100 : 4'b0011;
        acc.wdata   = {(LANES / 2){store_data[HALF_W-1:0]}};
      end
      default: begin
        acc.byte_en = '1;
        acc.wdata   = store_data;
      end
    endcase
    if (size == SZ_NONE) begin
      acc.status = ST_BAD_WIDTH;
    end else if (misaligned) begin
      acc.status    = ST_MISALIGNED;
      acc.reg_write = command == CMD_LOAD;
    end else if (!in_range) begin
      acc.status = ST_RANGE;
    end else begin
      acc.status    = ST_OK;
      acc.reg_write = command == CMD_LOAD;
      acc.mem_en    = 1'b1;
    end
  end

endmodule

// File: rtl/lsu_align.sv
// Load alignment: select the addressed lanes of the read word and extend; zero unless an OK load.
// Depends on lsu_pkg.
module lsu_align (
  input  logic [lsu_pkg::DATA_W-1:0] rdata,
  input  logic [lsu_pkg::LANE_W-1:0] lane,
  input  logic [lsu_pkg::WC_W-1:0]   width_code,
  input  lsu_pkg::status_t           status,
  input  logic                       reg_write,
  output logic [lsu_pkg::DATA_W-1:0] load_value
);
  import lsu_pkg::*;

  logic [DATA_W-1:0] shifted;
  logic [DATA_W-1:0] ext;

  assign shifted = rdata >> {lane, 3'b000};

  always_comb begin
    case (width_code)
      WC_BYTE:  ext = {{(DATA_W - BYTE_W){shifted[BYTE_W-1]}}, shifted[BYTE_W-1:0]};
      WC_BYTEU: ext = {{(DATA_W - BYTE_W){1'b0}}, shifted[BYTE_W-1:0]};
      WC_HALF:  ext = {{(DATA_W - HALF_W){shifted[HALF_W-1]}}, shifted[HALF_W-1:0]};
      WC_HALFU: ext = {{(DATA_W - HALF_W){1'b0}}, shifted[HALF_W-1:0]};
      default:  ext = shifted;
    endcase
  end

  assign load_value = (status == ST_OK && reg_write) ? ext : '0;

endmodule

// File: rtl/riscv_load_store_unit.sv
// Top level of the load/store unit: address stage, RAM access stage, output.
// Depends on lsu_pkg, lsu_decode, lsu_align and lsu_ram.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one load or store with its
//   base value, signed offset, store data, width code and destination index.
//   Response channel (rsp_valid/rsp_ready) returns exactly one response per
//   request, in order: reg_write, dest_reg_out, load_value and status.
//   A request taken into the address stage registers moves on, once the
//   output stage is free, into the RAM access stage registers that drive the response.
//   Throughput: one request per cycle while rsp_ready does not hold a response.
//   The single RAM port serves one read or one byte-enabled write each cycle.
//   Stall: when rsp_ready is low the response and RAM read data hold; the
//   address stage still takes one more request, then req_ready drops.
//   Reset: clears both pipeline valid bits. RAM contents are undefined until
//   written; loads of never-written words return unspecified data.
module riscv_load_store_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                command,
  input  logic [lsu_pkg::ADDR_W-1:0]          base_value,
  input  logic signed [lsu_pkg::OFFSET_W-1:0] offset,
  input  logic [lsu_pkg::DATA_W-1:0]          store_data,
  input  logic [lsu_pkg::WC_W-1:0]            width_code,
  input  logic [lsu_pkg::REG_W-1:0]           dest_reg,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                reg_write,
  output logic [lsu_pkg::REG_W-1:0]           dest_reg_out,
  output logic [lsu_pkg::DATA_W-1:0]          load_value,
  output logic [1:0]                          status
);
  import lsu_pkg::*;

  logic              s1_valid;
  logic              s1_command;
  logic [ADDR_W-1:0] s1_addr;
  logic [ADDR_W-1:0] s1_addr_next;
  logic [DATA_W-1:0] s1_data;
  logic [WC_W-1:0]   s1_wc;
  logic [REG_W-1:0]  s1_rd;

  logic              s2_valid;
  logic              s2_ready;
  status_t           s2_status;
  logic              s2_reg_write;
  logic [REG_W-1:0]  s2_rd;
  logic [LANE_W-1:0] s2_lane;
  logic [WC_W-1:0]   s2_wc;

  logic              s1_adv;
  access_t           acc;
  logic [DATA_W-1:0] ram_rdata;

  assign s2_ready     = !s2_valid || rsp_ready;
  assign req_ready    = !s1_valid || s2_ready;
  assign s1_adv       = s1_valid && s2_ready;
  assign s1_addr_next = base_value + {{(ADDR_W - OFFSET_W){offset[OFFSET_W-1]}}, offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_command <= command;
      s1_addr    <= s1_addr_next;
      s1_data    <= store_data;
      s1_wc      <= width_code;
      s1_rd      <= dest_reg;
    end
  end

  lsu_decode u_decode (
    .command    (s1_command),
    .addr       (s1_addr),
    .store_data (s1_data),
    .width_code (s1_wc),
    .acc        (acc)
  );

  lsu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .en    (s1_adv && acc.mem_en),
    .we    (acc.mem_we),
    .be    (acc.byte_en),
    .addr  (acc.idx),
    .wdata (acc.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_status    <= acc.status;
      s2_reg_write <= acc.reg_write;
      s2_rd        <= s1_rd;
      s2_lane      <= s1_addr[LANE_W-1:0];
      s2_wc        <= s1_wc;
    end
  end

  lsu_align u_align (
    .rdata      (ram_rdata),
    .lane       (s2_lane),
    .width_code (s2_wc),
    .status     (s2_status),
    .reg_write  (s2_reg_write),
    .load_value (load_value)
  );

  assign rsp_valid    = s2_valid;
  assign reg_write    = s2_reg_write;
  assign dest_reg_out = s2_rd;
  assign status       = s2_status;

`ifndef ASSERT_OFF
  a_ram_only_ok: assert property (@(posedge clk) disable iff (rst)
    s1_adv && acc.mem_en |-> acc.status == ST_OK)
    else $error("RAM access on a failed request");

  a_advance_fills_s2: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> s2_valid)
    else $error("advanced request lost before output stage");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reg_write |-> status == ST_OK || status == ST_MISALIGNED)
    else $error("register write on bad width or range error");

  a_zero_without_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !reg_write |-> load_value == '0)
    else $error("nonzero load value without register write");
`endif

endmodule

// File: tb/riscv_load_store_unit_test.sv
// Self-checking testbench for riscv_load_store_unit: directed and random loads and stores,
// checked field by field against a shadow memory kept inside the bench.
// Depends on lsu_pkg and the riscv_load_store_unit RTL.
module riscv_load_store_unit_test;
  import lsu_pkg::*;

  localparam logic [WC_W-1:0] WC_RSVD3 = 3'd3;
  localparam logic [WC_W-1:0] WC_RSVD6 = 3'd6;
  localparam logic [WC_W-1:0] WC_RSVD7 = 3'd7;

  localparam int EDGE_WORDS     = 64;
  localparam int LONG_HOLD      = 200;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int PRESSURE_ITEMS = 48;
  localparam int DRAIN_EVERY    = 300;
  localparam int MAX_REPORTS    = 50;

  typedef struct {
    logic                       cmd;
    logic [ADDR_W-1:0]          base;
    logic signed [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]          data;
    logic [WC_W-1:0]            wc;
    logic [REG_W-1:0]           rd;
  } mem_op_t;

  typedef struct {
    logic              reg_write;
    logic [REG_W-1:0]  dest;
    logic [DATA_W-1:0] value;
    status_t           status;
  } mem_rsp_t;

  typedef enum {RX_STEADY, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       req_valid;
  logic                       req_ready;
  logic                       command;
  logic [ADDR_W-1:0]          base_value;
  logic signed [OFFSET_W-1:0] offset;
  logic [DATA_W-1:0]          store_data;
  logic [WC_W-1:0]            width_code;
  logic [REG_W-1:0]           dest_reg;
  logic                       rsp_valid;
  logic                       rsp_ready;
  logic                       reg_write;
  logic [REG_W-1:0]           dest_reg_out;
  logic [DATA_W-1:0]          load_value;
  logic [1:0]                 status;

  logic [DATA_W-1:0] shadow_mem   [MEM_WORDS];
  logic [LANES-1:0]  shadow_lanes [MEM_WORDS];
  mem_rsp_t          pending_outcomes[$];
  mem_rsp_t          head_rsp;
  int                mismatch_count = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;
  bit                hold_off_req = 1'b0;

  riscv_load_store_unit uut (.*);

  always #4 clk = ~clk;

  function automatic int access_bytes(input logic [WC_W-1:0] wc);
    case (wc)
      WC_BYTE, WC_BYTEU: return 1;
      WC_HALF, WC_HALFU: return 2;
      WC_WORD:           return 4;
      default:           return 0;
    endcase
  endfunction

  function automatic logic [LANES-1:0] lane_bits(input int nbytes,
                                                 input logic [LANE_W-1:0] lane);
    return LANES'((1 << nbytes) - 1) << lane;
  endfunction

  function automatic logic [ADDR_W-1:0] widen_offset(input logic signed [OFFSET_W-1:0] off);
    return {{(ADDR_W-OFFSET_W){off[OFFSET_W-1]}}, off};
  endfunction

  function automatic mem_op_t access_at(input logic cmd, input logic [ADDR_W-1:0] ea,
                                        input int off,
                                        input logic [DATA_W-1:0] data,
                                        input logic [WC_W-1:0] wc, input int rd);
    mem_op_t op;
    op.cmd  = cmd;
    op.off  = OFFSET_W'(off);
    op.base = ea - widen_offset(op.off);
    op.data = data;
    op.wc   = wc;
    op.rd   = REG_W'(rd);
    return op;
  endfunction

  // Apply one access to the shadow memory and return the response it must produce.
  function automatic mem_rsp_t access_outcome(input mem_op_t op);
    logic [ADDR_W-1:0] ea;
    logic [WIDX_W-1:0] widx;
    logic [IDX_W-1:0]  sidx;
    logic [LANE_W-1:0] lane;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] raw;
    int                nbytes;
    int                shift;
    mem_rsp_t          rsp;
    ea     = op.base + widen_offset(op.off);
    widx   = ea[ADDR_W-1:LANE_W];
    sidx   = widx[IDX_W-1:0];
    lane   = ea[LANE_W-1:0];
    nbytes = access_bytes(op.wc);
    rsp.reg_write = 1'b0;
    rsp.dest      = op.rd;
    rsp.value     = '0;
    rsp.status    = ST_OK;
    if (nbytes == 0) begin
      rsp.status = ST_BAD_WIDTH;
    end else if ((ea & ADDR_W'(nbytes - 1)) != '0) begin
      rsp.status    = ST_MISALIGNED;
      rsp.reg_write = (op.cmd == CMD_LOAD);
    end else if (widx >= MEM_LIMIT) begin
      rsp.status = ST_RANGE;
    end else begin
      shift = lane * BYTE_W;
      mask  = (nbytes == 4) ? '1 : ((nbytes == 2) ? DATA_W'(16'hFFFF) : DATA_W'(8'hFF));
      if (op.cmd == CMD_STORE) begin
        shadow_mem[sidx]   = (shadow_mem[sidx] & ~(mask << shift)) | ((op.data & mask) << shift);
        shadow_lanes[sidx] = shadow_lanes[sidx] | lane_bits(nbytes, lane);
      end else begin
        raw = (shadow_mem[sidx] >> shift) & mask;
        if (op.wc == WC_BYTE)
          raw = {{(DATA_W-BYTE_W){raw[BYTE_W-1]}}, raw[BYTE_W-1:0]};
        else if (op.wc == WC_HALF)
          raw = {{(DATA_W-HALF_W){raw[HALF_W-1]}}, raw[HALF_W-1:0]};
        rsp.reg_write = 1'b1;
        rsp.value     = raw;
      end
    end
    return rsp;
  endfunction

  // Mostly well-formed traffic near both ends of memory; loads only touch written lanes.
  function automatic mem_op_t random_access();
    logic [WC_W-1:0]   good_wc[5] = '{WC_BYTE, WC_HALF, WC_WORD, WC_BYTEU, WC_HALFU};
    logic [WC_W-1:0]   split_wc[3] = '{WC_HALF, WC_HALFU, WC_WORD};
    logic [WC_W-1:0]   bad_wc[3] = '{WC_RSVD3, WC_RSVD6, WC_RSVD7};
    logic [ADDR_W-1:0] ea;
    logic [WIDX_W-1:0] widx;
    logic [LANE_W-1:0] lane;
    logic              cmd;
    logic [WC_W-1:0]   wc;
    int                pick;
    int                nbytes;
    pick = $urandom_range(0, 99);
    cmd  = 1'($urandom_range(0, 1));
    wc   = good_wc[$urandom_range(0, 4)];
    ea   = $urandom;
    if (pick < 80) begin
      widx = WIDX_W'($urandom_range(0, 2 * EDGE_WORDS - 1));
      if (widx >= EDGE_WORDS)
        widx = widx + WIDX_W'(MEM_WORDS - 2 * EDGE_WORDS);
      nbytes = access_bytes(wc);
      lane   = LANE_W'($urandom_range(0, LANES - 1) & ~(nbytes - 1));
      ea     = {widx, lane};
      cmd    = (pick < 40) ? CMD_STORE : CMD_LOAD;
      if (cmd == CMD_LOAD && (shadow_lanes[widx[IDX_W-1:0]] & lane_bits(nbytes, lane))
          != lane_bits(nbytes, lane))
        cmd = CMD_STORE;
    end else if (pick < 88) begin
      wc = split_wc[$urandom_range(0, 2)];
      if (access_bytes(wc) == 2)
        ea[0] = 1'b1;
      else
        ea[LANE_W-1:0] = LANE_W'($urandom_range(1, LANES - 1));
    end else if (pick < 94) begin
      wc = bad_wc[$urandom_range(0, 2)];
    end else begin
      if ($urandom_range(0, 1) == 0)
        widx = WIDX_W'(MEM_WORDS + $urandom_range(0, 7));
      else
        widx = WIDX_W'($urandom_range(MEM_WORDS, (1 << WIDX_W) - 1));
      nbytes = access_bytes(wc);
      ea = {widx, LANE_W'($urandom_range(0, LANES - 1) & ~(nbytes - 1))};
    end
    return access_at(cmd, ea, $urandom, $urandom, wc, $urandom);
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
  endtask

  task automatic send_access(input mem_op_t op);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    req_valid  <= 1'b1;
    command    <= op.cmd;
    base_value <= op.base;
    offset     <= op.off;
    store_data <= op.data;
    width_code <= op.wc;
    dest_reg   <= op.rd;
    do @(posedge clk); while (!req_ready);
    pending_outcomes.push_back(access_outcome(op));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_lane_extension();
    send_access(access_at(CMD_STORE, 32'h0, 1, 32'h8081_7F80, WC_WORD, 0));
    send_access(access_at(CMD_LOAD, 32'h0, 0, '0, WC_BYTE, 31));
    send_access(access_at(CMD_LOAD, 32'h1, -1, '0, WC_BYTEU, 1));
    send_access(access_at(CMD_LOAD, 32'h3, 5, '0, WC_BYTE, 2));
    send_access(access_at(CMD_LOAD, 32'h2, 0, '0, WC_HALF, 3));
    send_access(access_at(CMD_LOAD, 32'h0, 0, '0, WC_HALFU, 4));
    send_access(access_at(CMD_LOAD, 32'h0, 0, '0, WC_WORD, 5));
    send_access(access_at(CMD_STORE, 32'h1, 0, 32'hFFFF_FF12, WC_BYTEU, 6));
    send_access(access_at(CMD_STORE, 32'h2, 0, 32'h5555_AAAA, WC_HALFU, 7));
    send_access(access_at(CMD_STORE, 32'h4, 0, 32'hFFFF_0000, WC_HALF, 8));
    send_access(access_at(CMD_LOAD, 32'h4, 0, '0, WC_HALF, 9));
    send_access(access_at(CMD_LOAD, 32'h0, 0, '0, WC_WORD, 10));
  endtask

  task automatic test_address_boundaries();
    send_access(access_at(CMD_STORE, ADDR_W'((MEM_WORDS - 1) * LANES), -2048, '1, WC_WORD, 11));
    send_access(access_at(CMD_LOAD, ADDR_W'((MEM_WORDS - 1) * LANES), 2047, '0, WC_WORD, 12));
    send_access(access_at(CMD_STORE, ADDR_W'(MEM_WORDS * LANES), 0, '1, WC_WORD, 13));
    send_access(access_at(CMD_LOAD, ADDR_W'(MEM_WORDS * LANES + 3), 0, '0, WC_BYTEU, 14));
    send_access(access_at(CMD_LOAD, 32'hFFFF_FFFC, 0, '0, WC_WORD, 15));
  endtask

  task automatic test_error_precedence();
    send_access(access_at(CMD_LOAD, 32'h1, 0, '0, WC_HALF, 17));
    send_access(access_at(CMD_STORE, 32'h2, 0, '1, WC_WORD, 18));
    send_access(access_at(CMD_LOAD, 32'h3, 0, '0, WC_WORD, 19));
    send_access(access_at(CMD_LOAD, ADDR_W'(MEM_WORDS * LANES + 1), 0, '0, WC_HALFU, 20));
    send_access(access_at(CMD_LOAD, 32'h1, 0, '0, WC_RSVD3, 21));
    send_access(access_at(CMD_LOAD, 32'h2, 0, '0, WC_RSVD6, 22));
    send_access(access_at(CMD_STORE, 32'h0, 0, '1, WC_RSVD7, 23));
    send_access(access_at(CMD_LOAD, 32'h0, 0, '0, WC_WORD, 24));
  endtask

  task automatic test_response_backpressure();
    hold_off_req = 1'b1;
    burst_left   = PRESSURE_ITEMS;
    repeat (PRESSURE_ITEMS) send_access(random_access());
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
        wait_drained();
      send_access(random_access());
    end
  endtask

  initial begin
    foreach (shadow_mem[i]) begin
      shadow_mem[i]   = '0;
      shadow_lanes[i] = '0;
    end
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    command    <= CMD_LOAD;
    base_value <= '0;
    offset     <= '0;
    store_data <= '0;
    width_code <= WC_WORD;
    dest_reg   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lane_extension();
    test_address_boundaries();
    test_error_precedence();
    test_response_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : rsp_side
    rx_mode_t mode = RX_STEADY;
    int       phase_left = 0;
    int       tick = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready <= 1'b0;
        for (int k = 0; k < LONG_HOLD; k++) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = rx_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        tick++;
        case (mode)
          RX_STEADY: rsp_ready <= 1'b1;
          RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_ready <= (tick % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("response with none pending", load_value, '0);
      end else begin
        head_rsp = pending_outcomes.pop_front();
        if (reg_write !== head_rsp.reg_write)
          report_mismatch("reg_write", DATA_W'(reg_write), DATA_W'(head_rsp.reg_write));
        if (dest_reg_out !== head_rsp.dest)
          report_mismatch("dest_reg_out", DATA_W'(dest_reg_out), DATA_W'(head_rsp.dest));
        if (load_value !== head_rsp.value)
          report_mismatch("load_value", load_value, head_rsp.value);
        if (status !== head_rsp.status)
          report_mismatch("status", DATA_W'(status), DATA_W'(head_rsp.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
